FILE: rtl/ffrc_pkg.sv
package ffrc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int TOT_W     = 48;
	localparam int RATIO_W   = 32;
	localparam int CFG_W     = 24;
	localparam int PROD_W    = 57;
	localparam int EXT_W     = PROD_W - FRAC_BITS + 1;
	localparam int DVD_W     = TOT_W + FRAC_BITS;
	localparam int CNT_W     = $clog2(DVD_W);

	localparam logic [CFG_W-1:0] CAL_FACTOR_RST = CFG_W'(1) << FRAC_BITS;
	localparam logic [CFG_W-1:0] MIN_RATIO_RST  = CFG_W'(39322);
	localparam logic [CFG_W-1:0] MAX_RATIO_RST  = CFG_W'(104858);

	typedef enum logic [1:0] {
		CFG_CAL_FACTOR = 2'd0,
		CFG_MIN_RATIO  = 2'd1,
		CFG_MAX_RATIO  = 2'd2,
		CFG_MONITOR_EN = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NO_DATA  = 2'd1,
		STATUS_TOO_LOW  = 2'd2,
		STATUS_TOO_HIGH = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [31:0] amount_commanded;
		logic signed [31:0] amount_measured;
		logic               sensor_has_data;
	} in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               live_data;
		logic signed [31:0] last_ratio;
		logic signed [31:0] lowest_ratio;
		logic signed [31:0] highest_ratio;
		logic signed [31:0] average_ratio;
		logic               reversed;
	} out_t;

endpackage

FILE: rtl/filament_flow_ratio_checker_top.sv
// Path to out_valid: no sensor data goes straight to ST_OUT; else ST_MUL and ST_TOT, then
// ST_CHK while calibrating, the divider when comparing or ending calibration, and ST_OUT.
// Each ratio uses the shared bit-serial divider, run twice per compared item.
// Throughput: one item at a time; the next transfer is taken the cycle after the result
// is registered, later while an earlier result is still stalled.
// Reset (arst_n low) clears mode, totals, last/lowest/highest ratios, direction and out_valid at once.
module filament_flow_ratio_checker_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  ffrc_pkg::in_t              in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output ffrc_pkg::out_t             out_data,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [ffrc_pkg::CFG_W-1:0] cfg_data
);

	localparam int TW = ffrc_pkg::TOT_W;
	localparam int RW = ffrc_pkg::RATIO_W;
	localparam int EW = ffrc_pkg::EXT_W;
	localparam int DW = ffrc_pkg::DVD_W;
	localparam int CW = ffrc_pkg::CNT_W;
	localparam logic signed [TW-1:0] TEN = TW'(10) << ffrc_pkg::FRAC_BITS;
	localparam logic signed [RW-1:0] R_MAX = {1'b0, {(RW-1){1'b1}}};
	localparam logic signed [RW-1:0] R_MIN = {1'b1, {(RW-1){1'b0}}};

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_MUL   = 8'b0000_0010,
		ST_TOT   = 8'b0000_0100,
		ST_CHK   = 8'b0000_1000,
		ST_DIVL  = 8'b0001_0000,
		ST_DIV   = 8'b0010_0000,
		ST_DDONE = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	typedef enum logic [1:0] {
		M_IDLE = 2'd0,
		M_CAL  = 2'd1,
		M_CMP  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		DIV_SEED = 2'd0,
		DIV_LAST = 2'd1,
		DIV_AVG  = 2'd2
	} div_dest_t;

	function automatic logic signed [TW-1:0] sat48(input logic signed [TW:0] x);
		if (x[TW] != x[TW-1])
			sat48 = x[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
		else
			sat48 = x[TW-1:0];
	endfunction

	state_t    state_q;
	mode_t     mode_q;
	div_dest_t dest_q;

	logic [ffrc_pkg::CFG_W-1:0] cal_factor_q, min_ratio_q, max_ratio_q;
	logic                       monitor_en_q;

	logic signed [31:0]   cmd_q, meas_q;
	logic signed [EW-1:0] ext_q;
	logic signed [TW-1:0] tc_q, tm_q;
	logic signed [RW-1:0] last_q, min_q, max_q, avg_q;
	logic                 inv_q, live_q;
	logic [1:0]           status_q;

	logic                 out_valid_q;
	ffrc_pkg::out_t       out_q;

	// divider
	logic [DW-1:0]   dvd_q;
	logic [TW-1:0]   ud_q;
	logic [TW:0]     rem_q;
	logic [RW-1:0]   quo_q;
	logic            ovf_q, neg_q, dz_q, npos_q, nneg_q;
	logic [CW-1:0]   cnt_q;

	logic signed [TW-1:0] div_n, div_d;
	logic [TW:0]          trial, diff;
	logic                 take;
	logic                 big;
	logic signed [RW-1:0] div_res;

	logic signed [ffrc_pkg::PROD_W-1:0] prod;
	logic signed [EW-1:0]               ext_d;
	logic signed [TW:0]                 tc_sum, tm_sum, tm_neg;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign prod  = meas_q * $signed({1'b0, cal_factor_q});
	assign ext_d = inv_q ? -ext_q : ext_q;

	always_comb begin
		tc_sum = {{(TW-31){cmd_q[31]}}, cmd_q} + {tc_q[TW-1], tc_q};
		tm_neg = -{tm_q[TW-1], tm_q};
		if (mode_q == M_CMP)
			tm_sum = {{(TW+1-EW){ext_d[EW-1]}}, ext_d} + {tm_q[TW-1], tm_q};
		else
			tm_sum = {{(TW+1-EW){ext_q[EW-1]}}, ext_q} + {tm_q[TW-1], tm_q};
	end

	always_comb begin
		if (dest_q == DIV_LAST) begin
			div_n = {{(TW-EW){ext_q[EW-1]}}, ext_q};
			div_d = {{(TW-32){cmd_q[31]}}, cmd_q};
		end else begin
			div_n = tm_q;
			div_d = tc_q;
		end
	end

	assign trial = {rem_q[TW-1:0], dvd_q[DW-1]};
	assign diff  = trial - {1'b0, ud_q};
	assign take  = (trial >= {1'b0, ud_q});
	assign big   = ovf_q | quo_q[RW-1];

	always_comb begin
		if (dz_q)
			div_res = npos_q ? R_MAX : (nneg_q ? R_MIN : '0);
		else if (neg_q)
			div_res = big ? R_MIN : -$signed(quo_q);
		else
			div_res = (big || quo_q == {1'b0, {(RW-1){1'b1}}}) ? R_MAX : $signed(quo_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_factor_q <= ffrc_pkg::CAL_FACTOR_RST;
			min_ratio_q  <= ffrc_pkg::MIN_RATIO_RST;
			max_ratio_q  <= ffrc_pkg::MAX_RATIO_RST;
			monitor_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ffrc_pkg::CFG_CAL_FACTOR: cal_factor_q <= cfg_data;
				ffrc_pkg::CFG_MIN_RATIO:  min_ratio_q  <= cfg_data;
				ffrc_pkg::CFG_MAX_RATIO:  max_ratio_q  <= cfg_data;
				ffrc_pkg::CFG_MONITOR_EN: monitor_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= M_IDLE;
			dest_q      <= DIV_SEED;
			tc_q        <= '0;
			tm_q        <= '0;
			last_q      <= '0;
			min_q       <= '0;
			max_q       <= '0;
			inv_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q  <= in_data.amount_commanded;
						meas_q <= in_data.amount_measured;
						live_q <= 1'b0;
						avg_q  <= '0;
						if (in_data.sensor_has_data) begin
							status_q <= ffrc_pkg::STATUS_OK;
							state_q  <= ST_MUL;
						end else begin
							status_q <= ffrc_pkg::STATUS_NO_DATA;
							state_q  <= ST_OUT;
						end
					end
				end
				ST_MUL: begin
					// arithmetic shift rounds toward minus infinity
					ext_q   <= EW'(prod >>> ffrc_pkg::FRAC_BITS);
					state_q <= ST_TOT;
				end
				ST_TOT: begin
					case (mode_q)
						M_CAL: begin
							tc_q    <= sat48(tc_sum);
							tm_q    <= sat48(tm_sum);
							state_q <= ST_CHK;
						end
						M_CMP: begin
							tc_q    <= sat48(tc_sum);
							tm_q    <= sat48(tm_sum);
							ext_q   <= ext_d;
							dest_q  <= DIV_LAST;
							state_q <= ST_DIVL;
						end
						default: begin
							mode_q  <= M_CAL;
							tc_q    <= {{(TW-32){cmd_q[31]}}, cmd_q};
							tm_q    <= {{(TW-EW){ext_q[EW-1]}}, ext_q};
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_CHK: begin
					if (tc_q >= TEN) begin
						inv_q   <= tm_q[TW-1];
						if (tm_q[TW-1])
							tm_q <= sat48(tm_neg);
						mode_q  <= M_CMP;
						dest_q  <= DIV_SEED;
						state_q <= ST_DIVL;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_DIVL: begin
					neg_q  <= div_n[TW-1] ^ div_d[TW-1];
					dz_q   <= (div_d == '0);
					npos_q <= !div_n[TW-1] && (div_n != '0);
					nneg_q <= div_n[TW-1];
					dvd_q  <= {(div_n[TW-1] ? -div_n : div_n), {ffrc_pkg::FRAC_BITS{1'b0}}};
					ud_q   <= div_d[TW-1] ? -div_d : div_d;
					rem_q  <= '0;
					quo_q  <= '0;
					ovf_q  <= 1'b0;
					cnt_q  <= CW'(DW - 1);
					if (dest_q == DIV_AVG) begin
						live_q <= 1'b1;
						if (monitor_en_q) begin
							if (last_q < $signed({{(RW-ffrc_pkg::CFG_W){1'b0}}, min_ratio_q}))
								status_q <= ffrc_pkg::STATUS_TOO_LOW;
							else if (last_q >
								$signed({{(RW-ffrc_pkg::CFG_W){1'b0}}, max_ratio_q}))
								status_q <= ffrc_pkg::STATUS_TOO_HIGH;
						end
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= take ? diff : trial;
					dvd_q <= {dvd_q[DW-2:0], 1'b0};
					ovf_q <= ovf_q | quo_q[RW-1];
					quo_q <= {quo_q[RW-2:0], take};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= ST_DDONE;
				end
				ST_DDONE: begin
					case (dest_q)
						DIV_SEED: begin
							last_q  <= div_res;
							min_q   <= div_res;
							max_q   <= div_res;
							dest_q  <= DIV_AVG;
							state_q <= ST_DIVL;
						end
						DIV_LAST: begin
							last_q <= div_res;
							if (div_res > max_q)
								max_q <= div_res;
							else if (div_res < min_q)
								min_q <= div_res;
							dest_q  <= DIV_AVG;
							state_q <= ST_DIVL;
						end
						default: begin
							avg_q   <= div_res;
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_OUT: begin
					// hold until the output slot frees up
					if (!out_valid_q || !out_stall) begin
						out_q.status        <= status_q;
						out_q.live_data     <= live_q;
						out_q.last_ratio    <= last_q;
						out_q.lowest_ratio  <= min_q;
						out_q.highest_ratio <= max_q;
						out_q.average_ratio <= avg_q;
						out_q.reversed      <= inv_q;
						state_q             <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: verif/ffrc_flow_monitor.sv
`timescale 1ns / 1ps
module ffrc_flow_monitor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  ffrc_pkg::in_t              in_data,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  ffrc_pkg::out_t             out_data,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [ffrc_pkg::CFG_W-1:0] cfg_data,
	output int                         errors,
	output int                         pending
);
	import ffrc_pkg::*;

	localparam logic [1:0] M_IDLE = 2'd0;
	localparam logic [1:0] M_CAL  = 2'd1;
	localparam logic [1:0] M_CMP  = 2'd2;
	localparam longint T_MAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint T_MIN = -T_MAX - 1;
	localparam longint R_MAX = 64'sh7FFF_FFFF;
	localparam longint R_MIN = -R_MAX - 1;

	logic [CFG_W-1:0] cal_factor, min_allowed, max_allowed;
	logic             mon_en;
	logic [1:0]       mode;
	longint           tot_cmd, tot_meas, r_last, r_lo, r_hi;
	logic             inverted;
	out_t             flow_expected[$];

	function automatic longint clamp48(longint x);
		if (x > T_MAX) return T_MAX;
		if (x < T_MIN) return T_MIN;
		return x;
	endfunction

	function automatic longint ratio_of(longint n, longint d);
		logic   neg;
		longint un, ud, q, r;
		if (d == 0) return (n > 0) ? R_MAX : ((n < 0) ? R_MIN : 0);
		neg = (n < 0) != (d < 0);
		un = (n < 0) ? -n : n;
		ud = (d < 0) ? -d : d;
		q = un / ud;
		r = un % ud;
		if (q >= 64'sh1_0000_0000) return neg ? R_MIN : R_MAX;
		for (int i = 0; i < FRAC_BITS; i++) begin
			r = r <<< 1;
			q = q <<< 1;
			if (r >= ud) begin
				r -= ud;
				q |= 1;
			end
		end
		if (neg) return (q >= 64'sh8000_0000) ? R_MIN : -q;
		return (q >= R_MAX) ? R_MAX : q;
	endfunction

	function automatic out_t predict_flow(in_t it);
		out_t   o;
		longint cmd, ext, avg;
		logic   live;
		o = '0;
		avg = 0;
		live = 0;
		cmd = longint'(it.amount_commanded);
		if (!it.sensor_has_data) begin
			o.status = STATUS_NO_DATA;
		end else begin
			o.status = STATUS_OK;
			// arithmetic shift floors toward minus infinity
			ext = (longint'(it.amount_measured) * longint'({1'b0, cal_factor})) >>> FRAC_BITS;
			if (mode == M_CAL) begin
				tot_cmd = clamp48(tot_cmd + cmd);
				tot_meas = clamp48(tot_meas + ext);
				if (tot_cmd >= (longint'(10) <<< FRAC_BITS)) begin
					inverted = tot_meas < 0;
					if (inverted) tot_meas = clamp48(-tot_meas);
					r_last = ratio_of(tot_meas, tot_cmd);
					r_lo = r_last;
					r_hi = r_last;
					mode = M_CMP;
				end
			end else if (mode == M_CMP) begin
				tot_cmd = clamp48(tot_cmd + cmd);
				if (inverted) ext = -ext;
				tot_meas = clamp48(tot_meas + ext);
				r_last = ratio_of(ext, cmd);
				if (r_last > r_hi) r_hi = r_last;
				else if (r_last < r_lo) r_lo = r_last;
			end else begin
				mode = M_CAL;
				tot_cmd = cmd;
				tot_meas = ext;
			end
			if (mode == M_CMP) begin
				if (mon_en) begin
					if (r_last < longint'({1'b0, min_allowed})) o.status = STATUS_TOO_LOW;
					else if (r_last > longint'({1'b0, max_allowed})) o.status = STATUS_TOO_HIGH;
				end
				avg = ratio_of(tot_meas, tot_cmd);
				live = 1;
			end
		end
		o.live_data = live;
		o.last_ratio = r_last[31:0];
		o.lowest_ratio = r_lo[31:0];
		o.highest_ratio = r_hi[31:0];
		o.average_ratio = avg[31:0];
		o.reversed = inverted;
		return o;
	endfunction

	task automatic report(string what, longint e, longint a);
		$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, e, a);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t e;
		if (!arst_n) begin
			cal_factor <= CAL_FACTOR_RST;
			min_allowed <= MIN_RATIO_RST;
			max_allowed <= MAX_RATIO_RST;
			mon_en <= 0;
			mode = M_IDLE;
			tot_cmd = 0;
			tot_meas = 0;
			r_last = 0;
			r_lo = 0;
			r_hi = 0;
			inverted = 0;
			errors = 0;
			flow_expected.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_CAL_FACTOR: cal_factor <= cfg_data;
					CFG_MIN_RATIO:  min_allowed <= cfg_data;
					CFG_MAX_RATIO:  max_allowed <= cfg_data;
					CFG_MONITOR_EN: mon_en <= cfg_data[0];
				endcase
			end
			if (in_valid && !in_stall) flow_expected.push_back(predict_flow(in_data));
			if (out_valid && !out_stall) begin
				if (flow_expected.size() == 0) begin
					$display("%0t: unexpected result, actual %h", $time, out_data);
					errors++;
				end else begin
					e = flow_expected.pop_front();
					if (e.status != out_data.status)
						report("status", e.status, out_data.status);
					if (e.live_data != out_data.live_data)
						report("live_data", e.live_data, out_data.live_data);
					if (e.last_ratio != out_data.last_ratio)
						report("last_ratio", e.last_ratio, out_data.last_ratio);
					if (e.lowest_ratio != out_data.lowest_ratio)
						report("lowest_ratio", e.lowest_ratio, out_data.lowest_ratio);
					if (e.highest_ratio != out_data.highest_ratio)
						report("highest_ratio", e.highest_ratio, out_data.highest_ratio);
					if (e.average_ratio != out_data.average_ratio)
						report("average_ratio", e.average_ratio, out_data.average_ratio);
					if (e.reversed != out_data.reversed)
						report("reversed", e.reversed, out_data.reversed);
				end
			end
			pending = flow_expected.size();
		end
	end
endmodule

FILE: verif/filament_flow_ratio_checker_top_tb.sv
`timescale 1ns / 1ps
module filament_flow_ratio_checker_top_tb;
	import ffrc_pkg::*;

	logic             clk = 0;
	logic             arst_n = 0;
	logic             in_valid = 0;
	logic             in_stall;
	in_t              in_data = '0;
	logic             out_valid;
	logic             out_stall = 0;
	out_t             out_data;
	logic             cfg_we = 0;
	logic [1:0]       cfg_index = CFG_CAL_FACTOR;
	logic [CFG_W-1:0] cfg_data = '0;
	int               errors, pending;
	int               send_idle_pct = 0, recv_idle_pct = 0;
	int               hold_cycles = 0;
	logic             hold_req = 0;
	logic             hold_done = 0;

	filament_flow_ratio_checker_top uut (.*);
	ffrc_flow_monitor checker_i (.*);

	always #10 clk = ~clk;

	initial begin
		#40_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: random stall, or a long hold-off once requested
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			out_stall <= 1;
			hold_cycles <= hold_cycles + 1;
			if (hold_cycles == 2999) hold_done <= 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
	endtask

	task automatic send_segment(logic signed [31:0] c, logic signed [31:0] m, logic d);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{amount_commanded: c, amount_measured: m, sensor_has_data: d};
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain;
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_len();
		case ($urandom_range(9))
			0: return $urandom;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sh8000_0000;
			3: return 0;
			default: return $signed($urandom_range(32'h0008_0000)) - 32'sh0002_0000;
		endcase
	endfunction

	task automatic settings(int k);
		case (k % 4)
			0: begin
				write_reg(CFG_CAL_FACTOR, CAL_FACTOR_RST);
				write_reg(CFG_MIN_RATIO, MIN_RATIO_RST);
				write_reg(CFG_MAX_RATIO, MAX_RATIO_RST);
				write_reg(CFG_MONITOR_EN, CFG_W'(1));
			end
			1: begin
				write_reg(CFG_CAL_FACTOR, '1);
				write_reg(CFG_MIN_RATIO, '1);
				write_reg(CFG_MAX_RATIO, '1);
				write_reg(CFG_MONITOR_EN, '0);
			end
			2: begin
				write_reg(CFG_CAL_FACTOR, '0);
				write_reg(CFG_MIN_RATIO, '0);
				write_reg(CFG_MAX_RATIO, '0);
				write_reg(CFG_MONITOR_EN, CFG_W'(1));
			end
			default: begin
				write_reg(CFG_CAL_FACTOR, CFG_W'($urandom_range(24'h2_0000)));
				write_reg(CFG_MIN_RATIO, CFG_W'($urandom_range(24'h1_0000)));
				write_reg(CFG_MAX_RATIO, CFG_W'($urandom_range(24'h2_0000, 24'h1_0000)));
				write_reg(CFG_MONITOR_EN, CFG_W'(1));
			end
		endcase
		cfg_we <= 0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: no data, calibration, negative measured amount, zero and extreme lengths
		send_segment(32'sh0010_0000, 32'sh0010_0000, 0);
		send_segment(32'sh0005_0000, 32'sh0005_0000, 1);
		send_segment(32'sh0005_0000, 32'sh0005_0000, 1);
		send_segment(32'sh0001_0000, 32'sh0000_8000, 1);
		send_segment(0, 32'sh0001_0000, 1);
		send_segment(0, -32'sh0001_0000, 1);
		send_segment(0, 0, 1);
		send_segment(32'sh7FFF_FFFF, 32'sh8000_0000, 1);
		send_segment(32'sh8000_0000, 32'sh7FFF_FFFF, 1);
		send_segment(32'sh0001_0000, 32'sh0003_0000, 0);
		drain();
		write_reg(CFG_MONITOR_EN, CFG_W'(1));
		cfg_we <= 0;
		send_segment(32'sh0001_0000, 32'sh0000_1000, 1);
		send_segment(32'sh0001_0000, 32'sh0003_0000, 1);
		send_segment(32'sh0001_0000, 32'sh0001_0000, 1);
		for (int k = 0; k < 12; k++) begin
			drain();
			settings(k);
			case (k / 4)
				0: begin send_idle_pct = 9;  recv_idle_pct = 46; end
				1: begin send_idle_pct = 46; recv_idle_pct = 9;  end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			if (k == 5) hold_req = 1;
			for (int i = 0; i < 140; i++) begin
				logic signed [31:0] c, m;
				c = ($urandom_range(3) == 0) ? rand_len() :
					$signed($urandom_range(32'h0004_0000, 32'h0000_4000));
				m = ($urandom_range(3) == 0) ? rand_len() :
					c + $signed($urandom_range(32'h0001_0000)) - 32'sh0000_8000;
				if (k % 3 == 1 && $urandom_range(1)) m = -m;
				send_segment(c, m, $urandom_range(15) != 0);
			end
		end
		drain();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

FILE: files.f
rtl/ffrc_pkg.sv
rtl/filament_flow_ratio_checker_top.sv
verif/ffrc_flow_monitor.sv
verif/filament_flow_ratio_checker_top_tb.sv
